/* hdl/billet_feeder_sequencer_assert.svh */
// Assertion macros for the billet feeder sequencer.
`ifndef BILLET_FEEDER_SEQUENCER_ASSERT_SVH
`define BILLET_FEEDER_SEQUENCER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BFS_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("assertion failed");
`define BFS_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("assertion failed");
`else
`define BFS_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define BFS_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

/* hdl/bfs_pkg.sv */
// Package for the billet feeder sequencer: state codes, indexes, widths.
`timescale 1ns / 1ps
package bfs_pkg;
	localparam int SHIFT_BITS_DEF = 16;
	localparam int TIMER_BITS_DEF = 15;
	localparam int REG_BITS = 15;
	localparam logic [REG_BITS-1:0] METER_MAX = 15'd32767;

	typedef enum logic [3:0] {
		ST_ERR = 4'd0, ST_STOP = 4'd1, ST_START = 4'd2, ST_F0 = 4'd3,
		ST_F1 = 4'd4, ST_F2 = 4'd5, ST_F3 = 4'd6, ST_F4 = 4'd7,
		ST_F5 = 4'd8, ST_F6 = 4'd9, ST_F7 = 4'd10
	} seq_st_t;

	typedef enum logic [2:0] {
		MD_STOP = 3'd0, MD_CYCLE = 3'd1, MD_UNLOAD = 3'd2,
		MD_REVERSE = 3'd3, MD_ERR = 3'd4
	} mode_st_t;

	typedef enum logic [2:0] {
		FLT_NONE = 3'd0, FLT_S1 = 3'd1, FLT_S2 = 3'd2, FLT_S3 = 3'd3,
		FLT_S4 = 3'd4, FLT_ROT = 3'd5, FLT_ESTOP = 3'd6
	} fault_t;

	typedef enum logic [2:0] {
		REG_MOVE = 3'd0, REG_ROTATE = 3'd1, REG_CYCLE = 3'd2, REG_RETRY = 3'd3,
		REG_IGN_S1 = 3'd4, REG_IGN_S23 = 3'd5, REG_IGN_S4 = 3'd6, REG_INV_S6 = 3'd7
	} reg_idx_t;

	// drive bit positions
	localparam int D_P1 = 0;
	localparam int D_P2 = 1;
	localparam int D_P3 = 2;
	localparam int D_M1 = 3;
	localparam int D_M2 = 4;
	localparam int D_M3 = 5;
	localparam int D_M3R = 6;
	// billet flag positions
	localparam int FL_Z2 = 0;
	localparam int FL_Z3 = 1;
	localparam int FL_Z4 = 2;
endpackage

/* hdl/billet_feeder_sequencer.sv */
// Billet feeder sequencer top level: one control tick per input item.
//
// Each accepted item is one control tick; the feed, advance and mode machines
// are evaluated together from the held state and the tick's levels, and the
// result item is registered. A new tick is accepted every cycle as long as
// the result register is empty or being drained, so the block runs at one
// item per cycle; result valid follows in the cycle after acceptance.
// Configuration is written through cfg_valid/cfg_ready at any time the block
// is idle.
`timescale 1ns / 1ps
`include "billet_feeder_sequencer_assert.svh"
module billet_feeder_sequencer #(
	parameter int SHIFT_BITS = bfs_pkg::SHIFT_BITS_DEF,
	parameter int TIMER_BITS = bfs_pkg::TIMER_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// s1, s2, s3, s4, s6, cycle, unload, reverse, estop_ok, service; 6 zero pad
	input  logic [15:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// p1,p2,p3,m1,m2,m3,m3r[6:0], fault[9:7], feed[13:10], adv[17:14],
	// billets[SHIFT_BITS+17:18], measured cycle next 15 bits, zero pad
	output logic [((SHIFT_BITS+33+7)/8)*8-1:0] m_axis_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [14:0] cfg_data
);
	localparam int RB = bfs_pkg::REG_BITS;
	localparam int OW = ((SHIFT_BITS+33+7)/8)*8;
	localparam int PAD = OW - SHIFT_BITS - 33;

	// configuration registers
	logic [RB-1:0] move_time_q, rotate_time_q, cycle_time_q, retry_limit_q;
	logic ign_s1_q, ign_s23_q, ign_s4_q, inv_s6_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_time_q <= 15'd50; rotate_time_q <= 15'd500;
			cycle_time_q <= '0; retry_limit_q <= 15'd3;
			ign_s1_q <= 1'b0; ign_s23_q <= 1'b0; ign_s4_q <= 1'b0; inv_s6_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				bfs_pkg::REG_MOVE:    move_time_q <= cfg_data;
				bfs_pkg::REG_ROTATE:  rotate_time_q <= cfg_data;
				bfs_pkg::REG_CYCLE:   cycle_time_q <= cfg_data;
				bfs_pkg::REG_RETRY:   retry_limit_q <= cfg_data;
				bfs_pkg::REG_IGN_S1:  ign_s1_q <= cfg_data[0];
				bfs_pkg::REG_IGN_S23: ign_s23_q <= cfg_data[0];
				bfs_pkg::REG_IGN_S4:  ign_s4_q <= cfg_data[0];
				bfs_pkg::REG_INV_S6:  inv_s6_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// timer loads fit the 15-bit registers to the timer width, truncating or zero-extending
	function automatic logic [TIMER_BITS-1:0] ld(input logic [RB-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[TIMER_BITS-1:0];
	endfunction

	// machine state
	bfs_pkg::seq_st_t feed_q, adv_q;
	bfs_pkg::mode_st_t mode_q;
	logic [TIMER_BITS-1:0] feed_tmr_q, adv_tmr_q, cyc_tmr_q;
	logic [RB-1:0] meter_q, retries_q, last_q;
	logic auto_q, next_q;
	logic [2:0] flags_q;
	logic [SHIFT_BITS-1:0] shift_q;
	logic [6:0] drv_q;
	bfs_pkg::fault_t fault_q;

	bfs_pkg::seq_st_t feed_d, adv_d;
	bfs_pkg::mode_st_t mode_d;
	logic [TIMER_BITS-1:0] feed_tmr_d, adv_tmr_d, cyc_tmr_d;
	logic [RB-1:0] meter_d, retries_d, last_d;
	logic auto_d, next_d;
	logic [2:0] flags_d;
	logic [SHIFT_BITS-1:0] shift_d;
	logic [6:0] drv_d;
	bfs_pkg::fault_t fault_d;

	logic s1, s2, s3, s4, s6, cyc, unl, rev, ok, svc;
	logic s2_on, s4_on, s2_off, lvl;
	logic tick;

	assign {svc, ok, rev, unl, cyc, s6, s4, s3, s2, s1} = s_axis_tdata[9:0];
	assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
	assign tick = s_axis_tvalid && s_axis_tready;

	// next-state logic: timers, then feed, advance and mode in order
	always_comb begin
		feed_d = feed_q; adv_d = adv_q; mode_d = mode_q;
		feed_tmr_d = feed_tmr_q; adv_tmr_d = adv_tmr_q; cyc_tmr_d = cyc_tmr_q;
		meter_d = meter_q; retries_d = retries_q; last_d = last_q;
		auto_d = auto_q; next_d = next_q; flags_d = flags_q;
		shift_d = shift_q; drv_d = drv_q; fault_d = fault_q;
		s2_on = s2 && !ign_s23_q;
		s4_on = s4 && !ign_s4_q;
		s2_off = !s2 && !ign_s23_q;
		lvl = s6 ^ inv_s6_q;
		if (!svc) begin
			if (cyc_tmr_d != '0) cyc_tmr_d = cyc_tmr_d - 1'b1;
			if (feed_tmr_d != '0) feed_tmr_d = feed_tmr_d - 1'b1;
			if (adv_tmr_d != '0) adv_tmr_d = adv_tmr_d - 1'b1;
			if (meter_d < bfs_pkg::METER_MAX) meter_d = meter_d + 1'b1;

			// feed machine
			case (feed_q)
				bfs_pkg::ST_ERR: begin
					drv_d[bfs_pkg::D_P1] = 1'b0; drv_d[bfs_pkg::D_P2] = 1'b0;
					drv_d[bfs_pkg::D_M1] = 1'b0;
					if (!auto_q) feed_d = bfs_pkg::ST_STOP;
				end
				bfs_pkg::ST_STOP: begin
					drv_d[bfs_pkg::D_P1] = 1'b0; drv_d[bfs_pkg::D_P2] = 1'b0;
					drv_d[bfs_pkg::D_M1] = 1'b0;
					fault_d = bfs_pkg::FLT_NONE;
					if (auto_q) feed_d = bfs_pkg::ST_START;
				end
				bfs_pkg::ST_START: begin
					retries_d = retry_limit_q;
					feed_d = bfs_pkg::ST_F0;
					drv_d[bfs_pkg::D_M1] = 1'b1;
				end
				bfs_pkg::ST_F0: begin
					drv_d[bfs_pkg::D_P1] = 1'b1; feed_tmr_d = ld(move_time_q);
					feed_d = bfs_pkg::ST_F1;
				end
				bfs_pkg::ST_F1: begin
					if (feed_tmr_d == '0) begin
						drv_d[bfs_pkg::D_P1] = 1'b0; feed_tmr_d = ld(move_time_q);
						feed_d = bfs_pkg::ST_F2;
						flags_d[bfs_pkg::FL_Z3] = flags_d[bfs_pkg::FL_Z2];
					end
				end
				bfs_pkg::ST_F2, bfs_pkg::ST_F3: begin
					if (feed_q == bfs_pkg::ST_F2 && feed_tmr_d == '0) begin
						if (s1 && !ign_s1_q) begin
							if (retries_d != '0) begin
								retries_d = retries_d - 1'b1;
								feed_d = auto_q ? bfs_pkg::ST_F0 : bfs_pkg::ST_STOP;
							end else begin
								fault_d = bfs_pkg::FLT_S1; feed_d = bfs_pkg::ST_ERR;
							end
							flags_d[bfs_pkg::FL_Z2] = 1'b0;
						end else begin
							feed_d = bfs_pkg::ST_F3;
							flags_d[bfs_pkg::FL_Z2] = 1'b1;
						end
					end
					// wait for the gate: a pending billet moves on to F4
					if (next_d) begin
						next_d = 1'b0;
						drv_d[bfs_pkg::D_P2] = 1'b1; feed_tmr_d = ld(move_time_q);
						feed_d = bfs_pkg::ST_F4;
					end
				end
				bfs_pkg::ST_F4: begin
					if (s4_on) begin
						drv_d[bfs_pkg::D_P2] = 1'b0; feed_tmr_d = ld(move_time_q);
						feed_d = bfs_pkg::ST_F5;
						flags_d[bfs_pkg::FL_Z4] = 1'b1;
					end
					if (feed_tmr_d == '0) begin
						drv_d[bfs_pkg::D_P2] = 1'b0; feed_tmr_d = ld(move_time_q);
						feed_d = bfs_pkg::ST_F6;
						if (s2_on) begin
							fault_d = bfs_pkg::FLT_S2; feed_d = bfs_pkg::ST_ERR;
						end
					end
				end
				bfs_pkg::ST_F5: begin
					if (feed_tmr_d == '0) begin
						if (s4_on) begin
							fault_d = bfs_pkg::FLT_S4; feed_d = bfs_pkg::ST_ERR;
						end else feed_d = auto_q ? bfs_pkg::ST_START : bfs_pkg::ST_STOP;
						if (s2_off) begin
							fault_d = bfs_pkg::FLT_S2; feed_d = bfs_pkg::ST_ERR;
						end
					end
				end
				bfs_pkg::ST_F6: begin
					if (s4_on) begin
						flags_d[bfs_pkg::FL_Z4] = 1'b1;
						feed_tmr_d = ld(move_time_q);
						feed_d = bfs_pkg::ST_F5;
					end
					if (feed_tmr_d == '0) begin
						flags_d[bfs_pkg::FL_Z4] = ign_s4_q;
						feed_d = auto_q ? bfs_pkg::ST_START : bfs_pkg::ST_STOP;
						if (s2_off) begin
							fault_d = bfs_pkg::FLT_S2; feed_d = bfs_pkg::ST_ERR;
						end
					end
				end
				default: ;
			endcase

			// advance machine
			case (adv_q)
				bfs_pkg::ST_ERR: begin
					drv_d[bfs_pkg::D_M2] = 1'b0; drv_d[bfs_pkg::D_M3] = 1'b0;
					drv_d[bfs_pkg::D_M3R] = 1'b0;
					if (!auto_q) adv_d = bfs_pkg::ST_STOP;
				end
				bfs_pkg::ST_STOP: begin
					drv_d[bfs_pkg::D_P3] = 1'b0;
					fault_d = bfs_pkg::FLT_NONE;
					if (auto_q) adv_d = bfs_pkg::ST_START;
				end
				bfs_pkg::ST_START: begin
					adv_d = bfs_pkg::ST_F0;
					drv_d[bfs_pkg::D_M2] = 1'b1;
					if (!s3 && !ign_s23_q) begin
						fault_d = bfs_pkg::FLT_S3; adv_d = bfs_pkg::ST_ERR;
					end
				end
				bfs_pkg::ST_F0: begin
					if (feed_d >= bfs_pkg::ST_STOP && feed_d <= bfs_pkg::ST_F3)
						drv_d[bfs_pkg::D_P3] = 1'b1;
					adv_tmr_d = ld(move_time_q);
					adv_d = bfs_pkg::ST_F1;
				end
				bfs_pkg::ST_F1: begin
					if (adv_tmr_d == '0) begin
						adv_d = bfs_pkg::ST_F2; adv_tmr_d = ld(rotate_time_q);
					end
				end
				bfs_pkg::ST_F2, bfs_pkg::ST_F3: begin
					drv_d[bfs_pkg::D_M3] = 1'b1;
					if (adv_q == bfs_pkg::ST_F2) begin
						if (!lvl) adv_d = bfs_pkg::ST_F3;
					end else if (lvl) adv_d = bfs_pkg::ST_F4;
					if (adv_tmr_d == '0) begin
						adv_tmr_d = ld(move_time_q);
						adv_d = bfs_pkg::ST_F6;
						drv_d[bfs_pkg::D_M3] = 1'b0;
					end
				end
				bfs_pkg::ST_F4: begin
					shift_d = {shift_q[SHIFT_BITS-2:0], 1'b0};
					adv_d = bfs_pkg::ST_F5;
					if (drv_d[bfs_pkg::D_P3]) begin
						if (s3 && !ign_s23_q) begin
							fault_d = bfs_pkg::FLT_S3; adv_d = bfs_pkg::ST_ERR;
						end else begin
							shift_d[0] = flags_d[bfs_pkg::FL_Z4];
							flags_d[bfs_pkg::FL_Z4] = 1'b0;
							next_d = 1'b1;
						end
					end
					drv_d[bfs_pkg::D_P3] = 1'b0; drv_d[bfs_pkg::D_M3] = 1'b0;
					adv_tmr_d = ld(move_time_q);
				end
				bfs_pkg::ST_F5: begin
					next_d = 1'b0;
					if (adv_tmr_d == '0 && cyc_tmr_d == '0) begin
						if (auto_q) adv_d = bfs_pkg::ST_START;
						else begin
							adv_d = bfs_pkg::ST_STOP;
							drv_d[bfs_pkg::D_M2] = 1'b0; drv_d[bfs_pkg::D_M3] = 1'b0;
						end
						cyc_tmr_d = ld(cycle_time_q);
						last_d = meter_d;
						meter_d = '0;
					end
				end
				bfs_pkg::ST_F6: begin
					if (adv_tmr_d == '0) begin
						adv_tmr_d = ld(move_time_q);
						adv_d = bfs_pkg::ST_F7;
						drv_d[bfs_pkg::D_M3R] = 1'b1;
					end
				end
				bfs_pkg::ST_F7: begin
					if (adv_tmr_d == '0) begin
						adv_d = bfs_pkg::ST_ERR; fault_d = bfs_pkg::FLT_ROT;
					end
				end
				default: ;
			endcase

			// mode machine
			case (mode_q)
				bfs_pkg::MD_ERR: begin
					drv_d[bfs_pkg::D_M1] = 1'b0; drv_d[bfs_pkg::D_M2] = 1'b0;
					drv_d[bfs_pkg::D_M3] = 1'b0; drv_d[bfs_pkg::D_M3R] = 1'b0;
					if (ok) mode_d = bfs_pkg::MD_STOP;
				end
				bfs_pkg::MD_STOP: begin
					fault_d = bfs_pkg::FLT_NONE;
					if (cyc) mode_d = bfs_pkg::MD_CYCLE;
					if (unl) mode_d = bfs_pkg::MD_UNLOAD;
					if (rev) mode_d = bfs_pkg::MD_REVERSE;
				end
				bfs_pkg::MD_CYCLE: begin
					if (cyc) auto_d = 1'b1;
					else begin
						auto_d = 1'b0; mode_d = bfs_pkg::MD_STOP;
					end
					if (!ok) begin
						feed_d = bfs_pkg::ST_ERR; adv_d = bfs_pkg::ST_ERR;
						mode_d = bfs_pkg::MD_ERR; fault_d = bfs_pkg::FLT_ESTOP;
					end
				end
				bfs_pkg::MD_UNLOAD: begin
					if (unl) begin
						drv_d[bfs_pkg::D_M2] = 1'b1; drv_d[bfs_pkg::D_M3] = 1'b1;
					end else begin
						drv_d[bfs_pkg::D_M2] = 1'b0; drv_d[bfs_pkg::D_M3] = 1'b0;
						mode_d = bfs_pkg::MD_STOP;
					end
					if (!ok) begin
						mode_d = bfs_pkg::MD_ERR; fault_d = bfs_pkg::FLT_ESTOP;
					end
				end
				bfs_pkg::MD_REVERSE: begin
					if (rev) drv_d[bfs_pkg::D_M3R] = 1'b1;
					else begin
						drv_d[bfs_pkg::D_M3R] = 1'b0; mode_d = bfs_pkg::MD_STOP;
					end
					if (!ok) begin
						mode_d = bfs_pkg::MD_ERR; fault_d = bfs_pkg::FLT_ESTOP;
					end
				end
				default: ;
			endcase
		end
	end

	// state registers, updated once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_q <= bfs_pkg::ST_STOP; adv_q <= bfs_pkg::ST_STOP;
			mode_q <= bfs_pkg::MD_STOP;
			feed_tmr_q <= '0; adv_tmr_q <= '0; cyc_tmr_q <= '0;
			meter_q <= '0; retries_q <= '0; last_q <= '0;
			auto_q <= 1'b0; next_q <= 1'b0; flags_q <= '0;
			shift_q <= '0; drv_q <= '0; fault_q <= bfs_pkg::FLT_NONE;
		end else if (tick) begin
			feed_q <= feed_d; adv_q <= adv_d; mode_q <= mode_d;
			feed_tmr_q <= feed_tmr_d; adv_tmr_q <= adv_tmr_d; cyc_tmr_q <= cyc_tmr_d;
			meter_q <= meter_d; retries_q <= retries_d; last_q <= last_d;
			auto_q <= auto_d; next_q <= next_d; flags_q <= flags_d;
			shift_q <= shift_d; drv_q <= drv_d; fault_q <= fault_d;
		end
	end

	// result register
	logic out_vld_q;
	logic [OW-1:0] out_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (tick) out_vld_q <= 1'b1;
		else if (m_axis_tready) out_vld_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (tick)
			out_q <= {{PAD{1'b0}}, last_d, shift_d, 4'(adv_d), 4'(feed_d),
				3'(fault_d), drv_d};
	end
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = out_q;

	`BFS_ASSERT_NEXT(a_tick_out, clk, arst_n, tick, m_axis_tvalid)
	`BFS_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	`BFS_ASSERT_NEXT(a_service, clk, arst_n, tick && svc, $stable(shift_q) && $stable(feed_q))
	`BFS_ASSERT_IMP(a_seq_range, clk, arst_n, 1'b1, feed_q <= bfs_pkg::ST_F7 && adv_q <= bfs_pkg::ST_F7)
	`BFS_ASSERT_IMP(a_mode_range, clk, arst_n, 1'b1, mode_q <= bfs_pkg::MD_ERR)
endmodule
